// ----- sv/button_multi_click_classifier_macros.svh -----
// ----------------------------------------------------------------------------
// Button multi-click classifier assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MULTI_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_MULTI_CLICK_CLASSIFIER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BMCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmcc: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define BMCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmcc: same-cycle check failed");

`endif

// ----- sv/bmcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click classifier package
// Shared types, register indexes, reset values and action codes.
// ----------------------------------------------------------------------------
package bmcc_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned CFG_W           = 16;
    localparam int unsigned CFG_IDX_W       = 3;
    localparam int unsigned CLICK_W         = 8;
    localparam int unsigned ACTION_W        = 3;
    localparam int unsigned DEC_LIMIT       = 100;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(100);
    localparam logic [CFG_W-1:0] CLICK_MAX_RST  = CFG_W'(50);
    localparam logic [CFG_W-1:0] CLICK_MIN_RST  = CFG_W'(2);
    localparam logic [CFG_W-1:0] QUIET_GAP_RST  = CFG_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_HIGH = 3'd0,
        CFG_LONG_PRESS  = 3'd1,
        CFG_CLICK_MAX   = 3'd2,
        CFG_CLICK_MIN   = 3'd3,
        CFG_QUIET_GAP   = 3'd4
    } cfg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE   = 3'd0,
        ACT_SINGLE = 3'd1,
        ACT_DOUBLE = 3'd2,
        ACT_TRIPLE = 3'd3,
        ACT_LONG   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DOWN = 2'd1,
        PH_HELD = 2'd2,
        PH_UP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic             active_high;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] click_max_ticks;
        logic [CFG_W-1:0] click_min_ticks;
        logic [CFG_W-1:0] quiet_gap_ticks;
    } cfg_t;

endpackage

// ----- sv/bmcc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds polarity and tick thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module bmcc_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmcc_pkg::CFG_W-1:0]        cfg_data,
    output bmcc_pkg::cfg_t                    cfg
);
    import bmcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE_HIGH: cfg_next.active_high      = cfg_data[0];
                CFG_LONG_PRESS:  cfg_next.long_press_ticks = cfg_data;
                CFG_CLICK_MAX:   cfg_next.click_max_ticks  = cfg_data;
                CFG_CLICK_MIN:   cfg_next.click_min_ticks  = cfg_data;
                CFG_QUIET_GAP:   cfg_next.quiet_gap_ticks  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high      <= 1'b0;
            cfg_reg.long_press_ticks <= LONG_PRESS_RST;
            cfg_reg.click_max_ticks  <= CLICK_MAX_RST;
            cfg_reg.click_min_ticks  <= CLICK_MIN_RST;
            cfg_reg.quiet_gap_ticks  <= QUIET_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/bmcc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Press/release phase machine
// Tracks hold, release and click counts and judges each finished run.
// ----------------------------------------------------------------------------
module bmcc_core
#(
    parameter int unsigned COUNT_WIDTH = bmcc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin_level,
    input  bmcc_pkg::cfg_t    cfg,
    output bmcc_pkg::action_t action_next
);
    import bmcc_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] release_reg, release_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;
    logic [CLICK_W-1:0]     click_reg, click_next;
    logic                   seen_reg, seen_next;

    logic                   pressed;
    logic [COUNT_WIDTH-1:0] release_inc;
    logic [CMP_W-1:0]       hold_x;
    logic [CMP_W-1:0]       release_x;
    logic                   is_long;
    logic                   is_discard;
    logic                   is_judged;

    assign pressed = (pin_level == cfg.active_high);

    // release counter advances in idle only once a release has been seen
    assign release_inc = (seen_reg && (release_reg != {COUNT_WIDTH{1'b1}}))
                         ? release_reg + 1'b1 : release_reg;

    assign hold_x    = CMP_W'(hold_reg);
    assign release_x = CMP_W'(release_inc);

    assign is_long    = hold_x > CMP_W'(cfg.long_press_ticks);
    assign is_discard = (hold_x < CMP_W'(cfg.long_press_ticks)) &&
                        (hold_x > CMP_W'(cfg.click_max_ticks));
    assign is_judged  = (release_x > CMP_W'(cfg.quiet_gap_ticks)) &&
                        (hold_x > CMP_W'(cfg.click_min_ticks)) &&
                        (hold_x < CMP_W'(cfg.click_max_ticks));

    // next phase
    always_comb
    begin
        case (phase_reg)
            PH_IDLE: phase_next = pressed ? PH_DOWN : PH_IDLE;
            PH_DOWN: phase_next = PH_HELD;
            PH_HELD: phase_next = pressed ? PH_HELD : PH_UP;
            PH_UP:   phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    // counters and action
    always_comb
    begin
        release_next = release_reg;
        hold_next    = hold_reg;
        click_next   = click_reg;
        seen_next    = seen_reg;
        action_next  = ACT_NONE;
        case (phase_reg)
            PH_IDLE:
            begin
                release_next = release_inc;
                if (is_long || is_discard || is_judged)
                begin
                    release_next = '0;
                    hold_next    = '0;
                    click_next   = '0;
                    seen_next    = 1'b0;
                end
                if (is_long)
                begin
                    action_next = ACT_LONG;
                end
                else if (!is_discard && is_judged)
                begin
                    case (click_reg)
                        CLICK_W'(1): action_next = ACT_SINGLE;
                        CLICK_W'(2): action_next = ACT_DOUBLE;
                        CLICK_W'(3): action_next = ACT_TRIPLE;
                        default:     action_next = ACT_NONE;
                    endcase
                end
            end
            PH_DOWN:
            begin
                if (click_reg != {CLICK_W{1'b1}})
                begin
                    click_next = click_reg + 1'b1;
                end
                seen_next = 1'b0;
                hold_next = '0;
            end
            PH_HELD:
            begin
                if (pressed && (hold_reg != {COUNT_WIDTH{1'b1}}))
                begin
                    hold_next = hold_reg + 1'b1;
                end
            end
            PH_UP:
            begin
                seen_next    = 1'b1;
                release_next = '0;
                // a hold beyond the fixed limit does not count as a click
                if ((hold_x > CMP_W'(DEC_LIMIT)) && (click_reg != '0))
                begin
                    click_next = click_reg - 1'b1;
                end
            end
            default:
            begin
                action_next = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            release_reg <= '0;
            hold_reg    <= '0;
            click_reg   <= '0;
            seen_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            release_reg <= release_next;
            hold_reg    <= hold_next;
            click_reg   <= click_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

// ----- sv/bmcc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one action item until the receiver takes it; frees itself on take.
// ----------------------------------------------------------------------------
module bmcc_out_reg
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  bmcc_pkg::action_t      action_d,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   free,
    output bmcc_pkg::action_t      action_q
);
    import bmcc_pkg::*;

    logic    valid_reg, valid_next;
    action_t action_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action_d;
        end
    end

    assign out_valid = valid_reg;
    assign action_q  = action_reg;

endmodule

// ----- sv/button_multi_click_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button multi-click classifier
// Classifies a sampled button level stream into single, double and triple
// clicks and long presses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one pin_level sample per item (in_valid/in_ready).
//   Output channel returns exactly one action item per input item
//   (out_valid/out_ready): 0 none, 1 single, 2 double, 3 triple, 4 long.
//   The action is registered: an item accepted at one edge shows its action
//   from the next cycle on. Throughput is one item per cycle, set by the
//   single output register; the phase update is one short step per item.
//   If the receiver stalls, the result register holds its item and
//   in_ready drops until it is taken; nothing is lost.
//   Registers are written through cfg_we/cfg_index/cfg_data by the user
//   only while idle, not enforced; writes to unused indexes are ignored.
//   Reset puts the machine in idle with all counters at zero, empties the
//   result register and loads the default thresholds (active low, long
//   press 100, click max 50, click min 2, quiet gap 30).
// ----------------------------------------------------------------------------
module button_multi_click_classifier
#(
    parameter int unsigned COUNT_WIDTH = bmcc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bmcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmcc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              pin_level,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bmcc_pkg::ACTION_W-1:0]     action
);
    import bmcc_pkg::*;

    cfg_t    cfg;
    action_t action_next;
    action_t action_q;
    logic    step;

    assign step = in_valid && in_ready;

    bmcc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bmcc_core
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pin_level   (pin_level),
        .cfg         (cfg),
        .action_next (action_next)
    );

    bmcc_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .action_d  (action_next),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (in_ready),
        .action_q  (action_q)
    );

    assign action = action_q;

endmodule

// ----- sv/bmcc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the classifier's channels for item loss, duplication and stalls.
// ----------------------------------------------------------------------------
`include "button_multi_click_classifier_macros.svh"

module bmcc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [bmcc_pkg::ACTION_W-1:0]     action
);
    import bmcc_pkg::*;

    // a held result keeps its value
    `BMCC_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(action))

    // every accepted item shows up as a result next cycle
    `BMCC_ASSERT_NEXT(a_item_to_result, in_valid && in_ready, out_valid)

    // a stalled result blocks new items
    `BMCC_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)

    // a taken result with no new item leaves the output empty
    `BMCC_ASSERT_NEXT(a_no_repeat, out_valid && out_ready && !(in_valid && in_ready),
                      !out_valid)

endmodule

bind button_multi_click_classifier bmcc_checker u_bmcc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action)
);
